### rtl/framed_command_packet_parser_assert.svh
// assertion helpers shared by the checker
`ifndef FRAMED_COMMAND_PACKET_PARSER_ASSERT_SVH
`define FRAMED_COMMAND_PACKET_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FCPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define FCPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/fcpp_pkg.sv
`default_nettype none
package fcpp_pkg;

	localparam int unsigned BYTE_W       = 8;
	localparam int unsigned EVENT_W      = 2;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned BUFFER_DEPTH = 256;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
	localparam logic [BYTE_W-1:0] END_BYTE  = 8'h0D;

	localparam logic [BYTE_W-1:0] PROTOCOL_VERSION_RST = 8'd1;
	localparam logic [BYTE_W-1:0] COMMAND_LIMIT_RST    = 8'd11;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PROTOCOL_VERSION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_LIMIT    = 2'd1;

	// operation codes
	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result event codes
	localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
	localparam logic [EVENT_W-1:0] EV_ACCEPT = 2'd1;
	localparam logic [EVENT_W-1:0] EV_DROP   = 2'd2;
	localparam logic [EVENT_W-1:0] EV_READ   = 2'd3;

endpackage
`default_nettype wire

### rtl/fcpp_if.sv
`default_nettype none
interface fcpp_req_if import fcpp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [BYTE_W-1:0] rx_byte;
	logic [BYTE_W-1:0] read_index;

	modport source (output valid, op, rx_byte, read_index, input ready);
	modport sink (input valid, op, rx_byte, read_index, output ready);
endinterface

interface fcpp_rsp_if import fcpp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [EVENT_W-1:0] event_res;
	logic [BYTE_W-1:0]  frame_command;
	logic [BYTE_W-1:0]  frame_length;
	logic [BYTE_W-1:0]  payload_byte;

	modport source (output valid, event_res, frame_command, frame_length, payload_byte,
		input ready);
	modport sink (input valid, event_res, frame_command, frame_length, payload_byte,
		output ready);
endinterface
`default_nettype wire

### rtl/fcpp_ram.sv
`default_nettype none
module fcpp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### rtl/framed_command_packet_parser.sv
// framed command packet parser: sync, version, command, length, payload, checksum, end
// every beat's result is registered in the output stage and shown in the cycle after acceptance
// throughput: one beat per cycle while the output stage is empty or its beat is taken, set by
//   the phase update and the one write port plus one registered read port of the payload buffer
// reset: parser back to hunting, output stage empty, registers to version 1 and limit 11;
//   the payload buffer is not cleared
`default_nettype none
module framed_command_packet_parser import fcpp_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]      cfg_data,
	fcpp_req_if.sink                    req,
	fcpp_rsp_if.source                  rsp
);

	localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_VERSION,
		PH_COMMAND,
		PH_LENGTH,
		PH_PAYLOAD,
		PH_CHECK,
		PH_END
	} phase_t;

	// configuration registers
	logic [BYTE_W-1:0] protocol_version_q;
	logic [BYTE_W-1:0] command_limit_q;

	// parser state
	phase_t            phase_q;
	logic [BYTE_W-1:0] held_command_q;
	logic [BYTE_W-1:0] held_length_q;
	logic [BYTE_W-1:0] fill_count_q;
	logic [BYTE_W-1:0] running_sum_q;

	// output stage
	logic               valid_s1;
	logic [EVENT_W-1:0] event_s1;
	logic [BYTE_W-1:0]  command_s1;
	logic [BYTE_W-1:0]  length_s1;
	logic               read_s1;

	// next-state values
	phase_t             phase_d;
	logic [BYTE_W-1:0]  held_command_d;
	logic [BYTE_W-1:0]  held_length_d;
	logic [BYTE_W-1:0]  fill_count_d;
	logic [BYTE_W-1:0]  running_sum_d;
	logic [EVENT_W-1:0] event_d;
	logic               store_d;
	logic [BYTE_W-1:0]  fill_inc;

	logic              accept;
	logic              rx_beat;
	logic [BYTE_W-1:0] ram_rdata;

	// the output stage frees itself when its beat is taken, so a new beat
	// enters in the same cycle
	assign req.ready = !valid_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign rx_beat   = accept && (req.op == OP_RX);

	assign fill_inc = fill_count_q + 8'd1;

	// one step of the deframer for the byte on the input
	always_comb begin
		phase_d        = phase_q;
		held_command_d = held_command_q;
		held_length_d  = held_length_q;
		fill_count_d   = fill_count_q;
		running_sum_d  = running_sum_q;
		event_d        = EV_NONE;
		store_d        = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				// sum and fill count cleared on every hunting byte
				fill_count_d  = '0;
				running_sum_d = '0;
				if (req.rx_byte == SYNC_BYTE) begin
					phase_d = PH_VERSION;
				end
			end
			PH_VERSION: begin
				if (req.rx_byte == protocol_version_q) begin
					running_sum_d = req.rx_byte;
					phase_d       = PH_COMMAND;
				end else begin
					phase_d = PH_HUNT;
					event_d = EV_DROP;
				end
			end
			PH_COMMAND: begin
				held_command_d = req.rx_byte;
				if (req.rx_byte < command_limit_q) begin
					running_sum_d = running_sum_q + req.rx_byte;
					phase_d       = PH_LENGTH;
				end else begin
					phase_d = PH_HUNT;
					event_d = EV_DROP;
				end
			end
			PH_LENGTH: begin
				held_length_d = req.rx_byte;
				running_sum_d = running_sum_q + req.rx_byte;
				// empty payload goes straight to the checksum
				phase_d = (req.rx_byte != '0) ? PH_PAYLOAD : PH_CHECK;
			end
			PH_PAYLOAD: begin
				store_d       = 1'b1;
				running_sum_d = running_sum_q + req.rx_byte;
				fill_count_d  = fill_inc;
				if (fill_inc == held_length_q) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: begin
				if (~running_sum_q == req.rx_byte) begin
					phase_d = PH_END;
				end else begin
					phase_d = PH_HUNT;
					event_d = EV_DROP;
				end
			end
			PH_END: begin
				phase_d = PH_HUNT;
				event_d = (req.rx_byte == END_BYTE) ? EV_ACCEPT : EV_DROP;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// payload buffer: written during the payload phase, read by read beats
	fcpp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BUFFER_DEPTH)
	) u_payload_ram (
		.clk  (clk),
		.we   (rx_beat && store_d),
		.waddr(fill_count_q[ADDR_W-1:0]),
		.wdata(req.rx_byte),
		.re   (accept && (req.op == OP_READ)),
		.raddr(req.read_index[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_version_q <= PROTOCOL_VERSION_RST;
			command_limit_q    <= COMMAND_LIMIT_RST;
		end else if (cfg_write) begin
			if (cfg_index == REG_PROTOCOL_VERSION) begin
				protocol_version_q <= cfg_data;
			end else if (cfg_index == REG_COMMAND_LIMIT) begin
				command_limit_q <= cfg_data;
			end
		end
	end

	// parser state moves on stream bytes only, reads leave it alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			held_command_q <= '0;
			held_length_q  <= '0;
			fill_count_q   <= '0;
			running_sum_q  <= '0;
		end else if (rx_beat) begin
			phase_q        <= phase_d;
			held_command_q <= held_command_d;
			held_length_q  <= held_length_d;
			fill_count_q   <= fill_count_d;
			running_sum_q  <= running_sum_d;
		end
	end

	// output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// output stage payload; command and length shown on an accepted frame only
	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1 <= (req.op == OP_READ);
			if (req.op == OP_READ) begin
				event_s1   <= EV_READ;
				command_s1 <= '0;
				length_s1  <= '0;
			end else begin
				event_s1   <= event_d;
				command_s1 <= (event_d == EV_ACCEPT) ? held_command_q : '0;
				length_s1  <= (event_d == EV_ACCEPT) ? held_length_q : '0;
			end
		end
	end

	assign rsp.valid         = valid_s1;
	assign rsp.event_res     = event_s1;
	assign rsp.frame_command = command_s1;
	assign rsp.frame_length  = length_s1;
	// buffer read data holds until the next read beat is accepted
	assign rsp.payload_byte  = read_s1 ? ram_rdata : '0;

endmodule
`default_nettype wire

### rtl/fcpp_checker.sv
`default_nettype none
`include "framed_command_packet_parser_assert.svh"
module fcpp_checker import fcpp_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire logic               req_op,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire logic [EVENT_W-1:0] rsp_event_res,
	input wire logic [BYTE_W-1:0]  rsp_frame_command,
	input wire logic [BYTE_W-1:0]  rsp_frame_length,
	input wire logic [BYTE_W-1:0]  rsp_payload_byte
);

	logic req_beat;
	assign req_beat = req_valid && req_ready;

	`FCPP_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_event_res) && $stable(rsp_payload_byte),
		"stalled result beat changed")

	`FCPP_ASSERT_NXT(a_beat_gives_result, clk, arst_n, req_beat, rsp_valid,
		"accepted beat gave no result")

	`FCPP_ASSERT_NXT(a_read_event, clk, arst_n, req_beat && (req_op == OP_READ),
		rsp_event_res == EV_READ, "read beat not answered with read data")

	`FCPP_ASSERT_IMP(a_fields_zero, clk, arst_n, rsp_valid && (rsp_event_res != EV_ACCEPT),
		(rsp_frame_command == '0) && (rsp_frame_length == '0),
		"frame fields set without an accepted frame")

endmodule

bind framed_command_packet_parser fcpp_checker u_fcpp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_op           (req.op),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_event_res    (rsp.event_res),
	.rsp_frame_command(rsp.frame_command),
	.rsp_frame_length (rsp.frame_length),
	.rsp_payload_byte (rsp.payload_byte)
);
`default_nettype wire
